// File: rtl/core/integer_array_sorter_defines.svh
// assertion macros for the integer array sorter
`ifndef INTEGER_ARRAY_SORTER_DEFINES_SVH
`define INTEGER_ARRAY_SORTER_DEFINES_SVH

`ifndef SYNTH
`define IAS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define IAS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IAS_ASSERT_ALWAYS(lbl, expr, msg)
`define IAS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/ias_pkg.sv
package ias_pkg;

  localparam int WORD_W    = 32;
  localparam int DEPTH_DEF = 64;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  last;
  } in_item_t;

  typedef struct packed {
    word_t sorted_value;
    logic  last_out;
    logic  overflow;
  } out_item_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

// File: rtl/core/ias_cell.sv
module ias_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  ias_pkg::cell_ctl_t ctl,
  input  ias_pkg::word_t    new_val,
  input  ias_pkg::word_t    prev_val,
  input  logic              prev_vld,
  input  logic              prev_ins,
  input  ias_pkg::word_t    next_val,
  input  logic              next_vld,
  output ias_pkg::word_t    val,
  output logic              vld,
  output logic              ins
);

  ias_pkg::word_t val_r, val_nxt;
  logic           vld_r, vld_nxt;

  // new value belongs at or before this cell
  assign ins = !vld_r || (new_val < val_r);

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctl.load && ins) begin
      val_nxt = prev_ins ? prev_val : new_val;
      vld_nxt = vld_r | prev_vld;
    end else if (ctl.shift) begin
      val_nxt = next_val;
      vld_nxt = next_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule

// File: rtl/core/integer_array_sorter.sv
// fill: one integer accepted per cycle, inserted in sorted place by the cell row
// first result is valid the cycle after the last item of a set is accepted
// drain: one result per cycle from the head cell while out_ready is high
// no input is taken while a set drains; the new value fans out to every cell compare
// reset (synchronous, active low) empties all cells, clears the overflow flag, enters fill
`include "integer_array_sorter_defines.svh"

module integer_array_sorter #(
  parameter int DEPTH = ias_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ias_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ias_pkg::out_item_t out_data
);

  ias_pkg::state_t    state_r, state_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  ias_pkg::cell_ctl_t ctl;
  ias_pkg::word_t     cell_val [DEPTH];
  logic [DEPTH-1:0]   cell_vld;
  logic [DEPTH-1:0]   cell_ins;
  logic               full;
  logic               in_xfer;
  logic               out_xfer;
  logic               last_out;

  assign full      = cell_vld[DEPTH-1];
  assign in_ready  = (state_r == ias_pkg::ST_FILL);
  assign out_valid = (state_r == ias_pkg::ST_DRAIN) && cell_vld[0];
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign last_out  = !cell_vld[1];

  assign ctl.load  = in_xfer && !full;
  assign ctl.shift = out_xfer;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ias_pkg::word_t prev_val, next_val;
    logic           prev_vld, prev_ins, next_vld;

    if (i == 0) begin : g_head
      assign prev_val = in_data.value;
      assign prev_vld = 1'b1;
      assign prev_ins = 1'b0;
    end else begin : g_body
      assign prev_val = cell_val[i-1];
      assign prev_vld = cell_vld[i-1];
      assign prev_ins = cell_ins[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_val = '0;
      assign next_vld = 1'b0;
    end else begin : g_mid
      assign next_val = cell_val[i+1];
      assign next_vld = cell_vld[i+1];
    end

    ias_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .new_val  (in_data.value),
      .prev_val (prev_val),
      .prev_vld (prev_vld),
      .prev_ins (prev_ins),
      .next_val (next_val),
      .next_vld (next_vld),
      .val      (cell_val[i]),
      .vld      (cell_vld[i]),
      .ins      (cell_ins[i])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    ovf_nxt     = ovf_r;
    out_ovf_nxt = out_ovf_r;
    case (state_r)
      ias_pkg::ST_FILL: begin
        if (in_xfer) begin
          if (in_data.last) begin
            // set ends even when its last item is dropped
            out_ovf_nxt = ovf_r | full;
            ovf_nxt     = 1'b0;
            state_nxt   = ias_pkg::ST_DRAIN;
          end else if (full) begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ias_pkg::ST_DRAIN: begin
        if (out_xfer && last_out) begin
          state_nxt = ias_pkg::ST_FILL;
        end
      end
      default: begin
        state_nxt = ias_pkg::ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ias_pkg::ST_FILL;
      ovf_r     <= 1'b0;
      out_ovf_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ovf_r     <= ovf_nxt;
      out_ovf_r <= out_ovf_nxt;
    end
  end

  assign out_data.sorted_value = cell_val[0];
  assign out_data.last_out     = last_out;
  assign out_data.overflow     = out_ovf_r;

  `IAS_ASSERT_ALWAYS(a_no_overlap, !(in_ready && out_valid), "fill and drain overlap")
  `IAS_ASSERT_ALWAYS(a_packed_cells, ((cell_vld >> 1) & ~cell_vld) == '0, "hole in cell row")
  `IAS_ASSERT_IMPL(a_last_drains, in_xfer && in_data.last, out_valid, "no result after last item")
  `IAS_ASSERT_IMPL(a_run_continues, out_xfer && !last_out, out_valid, "sorted run cut short")

endmodule
